FILE: sv/wsp_pkg.sv
`default_nettype none
package wsp_pkg;

   localparam int CoefW     = 32;
   localparam int AccW      = 64;
   localparam int NdcW      = 38;                 // sign + 37 bits, |ndc| <= 2^36
   localparam int ProdW     = NdcW + CoefW;
   localparam int CfgW      = 12;
   localparam int HalfW     = CfgW - 1;
   localparam int PixW      = 16;
   localparam int ValW      = 52;                 // scaled screen value, Q.16
   localparam int QuotW     = 36;                 // 20 integer + 16 fraction bits
   localparam int FracW     = 16;
   localparam int ClampSh   = QuotW - FracW;

   localparam logic signed [AccW-1:0] NEAR_LIMIT = 64'sd6554 <<< FracW;
   localparam logic [CfgW-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CfgW-1:0] HEIGHT_RESET = 12'd480;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_PROJECT = 1'b1;

   // Truncate a Q.16 value toward zero and saturate to a signed pixel.
   function automatic logic signed [PixW-1:0] to_pixel(input logic signed [ValW-1:0] val);
      logic signed [ValW-FracW:0] p;
      p = (ValW-FracW+1)'(val >>> FracW);
      if (val[ValW-1] && (val[FracW-1:0] != '0))
         p = p + 1'b1;
      if (p > (ValW-FracW+1)'(32767))
         to_pixel = 16'sh7fff;
      else if (p < -(ValW-FracW+1)'(32768))
         to_pixel = 16'sh8000;
      else
         to_pixel = p[PixW-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: sv/wsp_mul.sv
`default_nettype none
module wsp_mul import wsp_pkg::*; (
   input  wire                            clock,
   input  wire logic signed [NdcW-1:0]    a,
   input  wire logic signed [CoefW-1:0]   b,
   output logic signed [ProdW-1:0]        p
);
   logic signed [ProdW-1:0] p_ff;
   logic signed [ProdW-1:0] p_in;

   assign p_in = a * b;
   assign p    = p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end
endmodule
`default_nettype wire

FILE: sv/world_to_screen_projection.sv
// Channel | Ports                                         | Direction
// req     | req_valid, req_stall, req_mode, coef, point   | in  (one request per item)
// rsp     | rsp_valid, rsp_stall, rsp_visible, screen x/y | out (one per project request)
// csr     | csr_write, csr_index, csr_data                | in  (width, height)
//
// Load request: written to the matrix on acceptance, no response. Project request: 3 clip rows
// x 4 terms, each a multiply and an accumulate state on the shared multiplier, then per axis
// a setup state, 36 restoring divider steps (skipped when the quotient clamps) and a scaling state.
// A hidden point skips the division. req_stall stays high from a project request until its
// result enters the output register, longer while a finished result waits on a stalled rsp.
// Synchronous reset clears the matrix to zero and the sizes to 640 x 480.
`default_nettype none
module world_to_screen_projection import wsp_pkg::*; (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire logic                    req_mode,
   input  wire logic [3:0]              req_coef_index,
   input  wire logic signed [31:0]      req_coef_value,
   input  wire logic signed [31:0]      req_point_x,
   input  wire logic signed [31:0]      req_point_y,
   input  wire logic signed [31:0]      req_point_z,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic                         rsp_visible,
   output logic signed [15:0]           rsp_screen_x,
   output logic signed [15:0]           rsp_screen_y,
   input  wire                          csr_write,
   input  wire logic                    csr_index,
   input  wire logic [11:0]             csr_data
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_MUL    = 7'b0000010,
      S_ACC    = 7'b0000100,
      S_DSTART = 7'b0001000,
      S_DIV    = 7'b0010000,
      S_SCALE  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [CfgW-1:0] width_ff, height_ff;
   logic [CoefW-1:0] mat_ff [16];

   logic signed [CoefW-1:0] pt_ff [3];
   logic [1:0]  row_ff, row_in;
   logic [1:0]  col_ff, col_in;
   logic        sc_wait_ff, sc_wait_in;          // scale: wait for product
   logic signed [AccW-1:0] acc_ff, acc_in;
   logic signed [AccW-1:0] cx_ff, cx_in, cy_ff, cy_in, cw_ff, cw_in;
   logic        axis_ff, axis_in;                // 0: x, 1: y
   logic        neg_ff, neg_in;
   logic [AccW-1:0]  rem_ff, rem_in;
   logic [QuotW-1:0] low_ff, low_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic signed [NdcW-1:0] ndc_ff, ndc_in;
   logic signed [PixW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic        vis_ff, vis_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_vis_ff, rsp_vis_in;
   logic signed [PixW-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic req_acc;
   logic signed [CoefW-1:0] coef_rd;
   logic signed [AccW-1:0]  trans;
   logic signed [NdcW-1:0]  mul_a;
   logic signed [CoefW-1:0] mul_b;
   logic signed [ProdW-1:0] mul_p;
   logic signed [AccW-1:0]  acc_sum;
   logic signed [AccW-1:0]  c_sel;
   logic [AccW-1:0]  mag;
   logic [AccW:0]    trial;
   logic             fits;
   logic [HalfW-1:0] half;
   logic signed [ValW-1:0] base, prod_v, val;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   assign coef_rd = mat_ff[{row_ff, col_ff}];
   assign trans   = AccW'(coef_rd) <<< FracW;

   // shared multiplier: matrix terms, then viewport scaling
   // (translation column takes no product)
   assign half  = axis_ff ? height_ff[CfgW-1:1] : width_ff[CfgW-1:1];
   assign mul_a = (state_ff == S_SCALE) ? ndc_ff :
                  (col_ff == 2'd3) ? '0 : NdcW'(pt_ff[col_ff]);
   assign mul_b = (state_ff == S_SCALE) ? CoefW'({1'b0, half}) : coef_rd;

   wsp_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p(mul_p));

   assign acc_sum = acc_ff + ((col_ff == 2'd3) ? trans : mul_p[AccW-1:0]);

   assign c_sel = axis_ff ? cy_ff : cx_ff;
   assign mag   = c_sel[AccW-1] ? AccW'(-c_sel) : AccW'(c_sel);
   assign fits  = (mag >> ClampSh) < AccW'(cw_ff);
   assign trial = {rem_ff, low_ff[QuotW-1]};

   assign base   = ValW'({1'b0, half}) <<< FracW;
   assign prod_v = mul_p[ValW-1:0];
   assign val    = axis_ff ? (base - prod_v) : (prod_v + base);

   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      sc_wait_in = sc_wait_ff;
      acc_in     = acc_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      cw_in      = cw_ff;
      axis_in    = axis_ff;
      neg_in     = neg_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      cnt_in     = cnt_ff;
      ndc_in     = ndc_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      vis_in     = vis_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_vis_in = rsp_vis_ff;
      rsp_x_in   = rsp_x_ff;
      rsp_y_in   = rsp_y_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && req_mode == MODE_PROJECT) begin
               row_in   = 2'd0;
               col_in   = 2'd0;
               acc_in   = '0;
               axis_in  = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ACC;                    // product lands in the multiplier register
         end
         S_ACC: begin
            acc_in = acc_sum;
            col_in = col_ff + 2'd1;
            state_in = S_MUL;
            if (col_ff == 2'd3) begin
               acc_in = '0;
               unique case (row_ff)
                  2'd0: begin
                     cx_in  = acc_sum;
                     row_in = 2'd1;
                  end
                  2'd1: begin
                     cy_in  = acc_sum;
                     row_in = 2'd3;              // z row is not needed
                  end
                  default: begin
                     cw_in = acc_sum;
                     if (acc_sum < NEAR_LIMIT) begin
                        vis_in   = 1'b0;
                        sx_in    = '0;
                        sy_in    = '0;
                        state_in = S_FINISH;
                     end else begin
                        vis_in   = 1'b1;
                        state_in = S_DSTART;
                     end
                  end
               endcase
            end
         end
         S_DSTART: begin
            neg_in     = c_sel[AccW-1];
            sc_wait_in = 1'b1;
            if (fits) begin
               rem_in   = mag >> ClampSh;
               low_in   = {mag[ClampSh-1:0], {FracW{1'b0}}};
               cnt_in   = 6'(QuotW - 1);
               state_in = S_DIV;
            end else begin
               // quotient clamped to 2^20 in magnitude
               ndc_in   = c_sel[AccW-1] ? -(NdcW'(1) <<< QuotW) : (NdcW'(1) <<< QuotW);
               state_in = S_SCALE;
            end
         end
         S_DIV: begin
            if (trial >= {1'b0, cw_ff}) begin
               rem_in = AccW'(trial - {1'b0, cw_ff});
               low_in = {low_ff[QuotW-2:0], 1'b1};
            end else begin
               rem_in = trial[AccW-1:0];
               low_in = {low_ff[QuotW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               ndc_in   = neg_ff ? -NdcW'({1'b0, low_in}) : NdcW'({1'b0, low_in});
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            sc_wait_in = 1'b0;
            if (!sc_wait_ff) begin
               if (axis_ff) begin
                  sy_in    = to_pixel(val);
                  state_in = S_FINISH;
               end else begin
                  sx_in    = to_pixel(val);
                  axis_in  = 1'b1;
                  state_in = S_DSTART;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_vis_in   = vis_ff;
               rsp_x_in     = sx_ff;
               rsp_y_in     = sy_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         for (int i = 0; i < 16; i++) mat_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index_type'(csr_index))
               CSR_WIDTH:  width_ff  <= csr_data;
               CSR_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
         if (req_acc && req_mode == MODE_LOAD)
            mat_ff[req_coef_index] <= req_coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         pt_ff[0] <= req_point_x;
         pt_ff[1] <= req_point_y;
         pt_ff[2] <= req_point_z;
      end
      row_ff     <= row_in;
      col_ff     <= col_in;
      sc_wait_ff <= sc_wait_in;
      acc_ff     <= acc_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      cw_ff      <= cw_in;
      axis_ff    <= axis_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      cnt_ff     <= cnt_in;
      ndc_ff     <= ndc_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      vis_ff     <= vis_in;
      rsp_vis_ff <= rsp_vis_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_visible  = rsp_vis_ff;
   assign rsp_screen_x = rsp_x_ff;
   assign rsp_screen_y = rsp_y_ff;

endmodule
`default_nettype wire

FILE: sv/wsp_checker.sv
`default_nettype none
module wsp_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_stall,
   input wire               req_mode,
   input wire               rsp_valid,
   input wire               rsp_stall,
   input wire               rsp_visible,
   input wire [15:0]        rsp_screen_x,
   input wire [15:0]        rsp_screen_y
);
   // a held result does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_screen_x) && $stable(rsp_screen_y)
         && $stable(rsp_visible))
      else $error("rsp changed while stalled");

   a_invis_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_screen_x == 16'd0 && rsp_screen_y == 16'd0)
      else $error("hidden point with nonzero position");

   a_project_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode |=> req_stall)
      else $error("project request did not occupy the block");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");
endmodule

bind world_to_screen_projection wsp_checker u_wsp_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_mode(req_mode), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_visible(rsp_visible), .rsp_screen_x(rsp_screen_x), .rsp_screen_y(rsp_screen_y)
);
`default_nettype wire

FILE: sim/tb_world_to_screen_projection.sv
`default_nettype none
module tb_world_to_screen_projection;
   import wsp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Watchdog limit: idle cycles with no request or response accepted.
   localparam int IdleLimit = 20000;
   localparam int BlockLatency = 120;

   typedef struct packed {
      logic               visible;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_mode = MODE_LOAD;
   logic [3:0] req_coef_index = '0;
   logic signed [31:0] req_coef_value = '0;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_visible;
   logic signed [15:0] rsp_screen_x;
   logic signed [15:0] rsp_screen_y;
   logic csr_write = 1'b0;
   logic csr_index = CSR_WIDTH;
   logic [11:0] csr_data = '0;

   world_to_screen_projection u_top (.*);

   always #2 clock = ~clock;

   // Predictor state: own copy of matrix and viewport sizes.
   logic [31:0] model_matrix [16];
   logic [11:0] model_width, model_height;
   pixel_type expected_pixels[$];

   int  errors = 0;
   int  send_idle_pct = 0;   // sender idle probability, percent
   int  stall_pct = 0;       // receiver stall probability, percent
   bit  hold_off = 1'b0;     // long receiver hold-off in progress
   int  idle_cycles = 0;

   // Truncating Q20.16 divide c/w, magnitude clamped at 2^20 integer.
   function automatic logic signed [63:0] ndc_quot(logic signed [63:0] c,
                                                   logic signed [63:0] w);
      logic        neg;
      logic [63:0] mag, q, r, frac;
      neg = c[63];
      mag = neg ? -c : c;
      q = mag / w;
      r = mag % w;
      if (q >= 64'd1048576)
         return neg ? -(64'sd1048576 <<< 16) : (64'sd1048576 <<< 16);
      frac = '0;
      for (int i = 0; i < 16; i++) begin
         r = r << 1;
         frac = frac << 1;
         if (r >= w) begin
            r = r - w;
            frac[0] = 1'b1;
         end
      end
      mag = (q << 16) | frac;
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [15:0] sat_pixel(logic signed [63:0] v);
      logic signed [63:0] p;
      p = v / 64'sd65536;   // truncates toward zero
      if (p > 64'sd32767) p = 64'sd32767;
      if (p < -64'sd32768) p = -64'sd32768;
      return p[15:0];
   endfunction

   function automatic logic signed [63:0] clip_row(int r, logic signed [31:0] x,
         logic signed [31:0] y, logic signed [31:0] z);
      logic signed [63:0] acc;
      acc = 64'(x) * 64'($signed(model_matrix[4*r]));
      acc += 64'(y) * 64'($signed(model_matrix[4*r+1]));
      acc += 64'(z) * 64'($signed(model_matrix[4*r+2]));
      acc += 64'($signed(model_matrix[4*r+3])) <<< 16;
      return acc;
   endfunction

   task automatic predict_request(logic mode, logic [3:0] idx, logic signed [31:0] cv,
         logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
      logic signed [63:0] cx, cy, cw, nx, ny, hw, hh;
      pixel_type px;
      if (mode == MODE_LOAD) begin
         model_matrix[idx] = cv;
         return;
      end
      cx = clip_row(0, x, y, z);
      cy = clip_row(1, x, y, z);
      cw = clip_row(3, x, y, z);
      if (cw < NEAR_LIMIT) begin
         px = '0;
      end else begin
         nx = ndc_quot(cx, cw);
         ny = ndc_quot(cy, cw);
         hw = 64'(model_width >> 1);
         hh = 64'(model_height >> 1);
         px.visible = 1'b1;
         px.sx = sat_pixel(hw * nx + (hw <<< 16));
         px.sy = sat_pixel((hh <<< 16) - hh * ny);
      end
      expected_pixels.push_back(px);
   endtask

   // Send one request; prediction happens at acceptance.
   // Request lines are only driven here, at the falling edge.
   task automatic send_request(logic mode, logic [3:0] idx, logic signed [31:0] cv,
         logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_mode = mode;
      req_coef_index = idx;
      req_coef_value = cv;
      req_point_x = x;
      req_point_y = y;
      req_point_z = z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(mode, idx, cv, x, y, z);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic load_coef(int idx, logic signed [31:0] v);
      send_request(MODE_LOAD, idx[3:0], v, $urandom, $urandom, $urandom);
   endtask

   task automatic project_point(logic signed [31:0] x, logic signed [31:0] y,
         logic signed [31:0] z);
      send_request(MODE_PROJECT, 4'($urandom), $urandom, x, y, z);
   endtask

   // Wait until all responses are back, plus settling, before a CSR write.
   task automatic drain;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (BlockLatency) @(negedge clock);
   endtask

   task automatic write_size(csr_index_type which, logic [11:0] v);
      drain();
      csr_write <= 1'b1;
      csr_index <= which;
      csr_data <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      if (which == CSR_WIDTH) model_width = v; else model_height = v;
   endtask

   // Random Q16.16 value: mostly moderate, sometimes full range.
   function automatic logic signed [31:0] rand_q16();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(65536*8)) - 32'sd262144;
         default: return $signed($urandom_range(65536*400)) - 32'sd13107200;
      endcase
   endfunction

   // A plausible perspective matrix with random content.
   task automatic load_random_camera;
      for (int i = 0; i < 16; i++) begin
         logic signed [31:0] v;
         v = $signed($urandom_range(131072)) - 32'sd65536;
         if (i == 0 || i == 5) v = $signed($urandom_range(262144));
         if (i == 14) v = $signed($urandom_range(98304));
         if (i == 15) v = $signed($urandom_range(65536));
         if ($urandom_range(9) == 0) v = $urandom;
         load_coef(i, v);
      end
   endtask

   // Response checker with random stall.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      pixel_type exp_px;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected response visible=%0d x=%0d y=%0d",
                      rsp_visible, rsp_screen_x, rsp_screen_y);
               errors++;
            end else begin
               exp_px = expected_pixels.pop_front();
               if (rsp_visible !== exp_px.visible) begin
                  $error("visible: expected %0d actual %0d", exp_px.visible, rsp_visible);
                  errors++;
               end
               if (rsp_screen_x !== exp_px.sx) begin
                  $error("screen_x: expected %0d actual %0d", exp_px.sx, rsp_screen_x);
                  errors++;
               end
               if (rsp_screen_y !== exp_px.sy) begin
                  $error("screen_y: expected %0d actual %0d", exp_px.sy, rsp_screen_y);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog.
   initial begin
      wait (!reset);
      wait (idle_cycles >= IdleLimit);
      $display("world_to_screen_projection test failed");
      $finish;
   end

   task automatic test_reset_defaults;
      // Zero matrix: w = 0, not visible.
      project_point(32'sh7fffffff, 32'sh80000000, 32'sd0);
      // Identity-ish with reset sizes.
      load_coef(0, 32'sd65536);
      load_coef(5, 32'sd65536);
      load_coef(15, 32'sd65536);
      project_point(32'sd32768, -32'sd32768, 32'sd0);
      project_point(32'sd0, 32'sd0, 32'sd0);
   endtask

   task automatic test_directed_edges;
      // Near limit boundary: w = m15<<16 exactly at and just below the limit.
      load_coef(15, 32'sd6554);
      project_point(32'sd65536, 32'sd65536, 32'sd0);
      load_coef(15, 32'sd6553);
      project_point(32'sd65536, 32'sd65536, 32'sd0);
      // Tiny w with huge x: NDC clamp and pixel saturation both ways.
      load_coef(15, 32'sd6554);
      load_coef(0, 32'sh7fffffff);
      load_coef(5, 32'sh80000000);
      project_point(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
      project_point(32'sh80000000, 32'sh80000000, 32'sh7fffffff);
      // Accumulator wrap: extreme coefficients in all terms of w.
      for (int i = 12; i < 16; i++) load_coef(i, 32'sh80000000);
      project_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
      // Negative fractional ndc exercises truncation toward zero.
      for (int i = 0; i < 16; i++) load_coef(i, 32'sd0);
      load_coef(0, 32'sd65536);
      load_coef(5, 32'sd65536);
      load_coef(15, 32'sd196608);
      project_point(-32'sd1, 32'sd1, 32'sd0);
      project_point(-32'sd100000, 32'sd100000, 32'sd0);
   endtask

   task automatic test_sizes;
      write_size(CSR_WIDTH, 12'd0);
      write_size(CSR_HEIGHT, 12'd1);
      project_point(32'sd30000, 32'sd30000, 32'sd0);
      write_size(CSR_WIDTH, 12'd4095);
      write_size(CSR_HEIGHT, 12'd4095);
      project_point(32'sd30000, -32'sd30000, 32'sd0);
      project_point(32'sd19660800, -32'sd19660800, 32'sd0);
   endtask

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) begin
         int k;
         k = $urandom_range(99);
         if (k < 6) load_coef($urandom_range(15), $urandom_range(1) ? $urandom : rand_q16());
         else if (k < 8) load_random_camera();
         else project_point(rand_q16(), rand_q16(), rand_q16());
      end
   endtask

   task automatic test_random_phases;
      int sizes[4][2] = '{'{640, 480}, '{4095, 4095}, '{1, 0}, '{1921, 1079}};
      for (int ph = 0; ph < 4; ph++) begin
         write_size(CSR_WIDTH, 12'(sizes[ph][0]));
         write_size(CSR_HEIGHT, 12'(sizes[ph][1]));
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 80; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 80; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         load_random_camera();
         run_random(330);
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_backpressure;
      // Receiver holds off for a long stretch while requests keep coming.
      fork
         begin
            hold_off = 1'b1;
            repeat (2000) @(negedge clock);
            hold_off = 1'b0;
         end
         run_random(30);
      join
      // Sender pauses until every response is back.
      while (expected_pixels.size() != 0) @(negedge clock);
      run_random(20);
   endtask

   initial begin
      for (int i = 0; i < 16; i++) model_matrix[i] = '0;
      model_width = WIDTH_RESET;
      model_height = HEIGHT_RESET;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_directed_edges();
      test_sizes();
      test_random_phases();
      test_backpressure();
      drain();
      if (errors == 0 && expected_pixels.size() == 0)
         $display("world_to_screen_projection test passed");
      else
         $display("world_to_screen_projection test failed");
      $finish;
   end
endmodule
`default_nettype wire
